[rtl/core/psmm_pkg.sv]
// Shared types, constants and helpers of the padded square matrix multiply.
// Used by every module in rtl/core; depends on nothing.
`default_nettype none
package psmm_pkg;

    localparam int MAX_DIM = 16;
    localparam int IDX_W   = $clog2(MAX_DIM);
    localparam int ADDR_W  = 2 * IDX_W;
    localparam int DATA_W  = 32;
    localparam int CFG_W   = 5;
    localparam int CIDX_W  = 2;
    localparam int OP_W    = 2;
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    typedef enum logic [OP_W-1:0] {
        OP_WR_A = 2'd0,
        OP_WR_B = 2'd1,
        OP_RD   = 2'd2,
        OP_NOP  = 2'd3
    } t_op;

    typedef enum logic [CIDX_W-1:0] {
        CFG_ROWS_A = 2'd0,
        CFG_COLS_A = 2'd1,
        CFG_ROWS_B = 2'd2,
        CFG_COLS_B = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        CMD_WR_A,
        CMD_WR_B,
        CMD_RD,
        CMD_RD_ZERO
    } t_cmd_kind;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_ISSUE,
        BK_DRAIN
    } t_back_state;

    typedef struct packed {
        logic [CFG_W-1:0] rows_a;
        logic [CFG_W-1:0] cols_a;
        logic [CFG_W-1:0] rows_b;
        logic [CFG_W-1:0] cols_b;
    } t_cfg;

    typedef struct packed {
        t_cmd_kind         kind;
        logic              oor;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [DATA_W-1:0] value;
    } t_cmd;

    localparam logic [CFG_W-1:0] DIM_LIMIT = CFG_W'(MAX_DIM);

    function automatic logic [CFG_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
        return (v > DIM_LIMIT) ? DIM_LIMIT : v;
    endfunction

    function automatic logic [CFG_W-1:0] inner_len(input t_cfg cfg);
        logic [CFG_W-1:0] ca;
        logic [CFG_W-1:0] rb;
        ca = eff_dim(cfg.cols_a);
        rb = eff_dim(cfg.rows_b);
        return (ca < rb) ? ca : rb;
    endfunction

endpackage
`default_nettype wire

[rtl/core/psmm_front.sv]
// Front end: accepts input beats, classifies them into back-end commands.
// Depends on psmm_pkg; feeds psmm_queue.
`default_nettype none
module psmm_front (
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [psmm_pkg::OP_W-1:0]    i_op,
    input  wire logic [psmm_pkg::IDX_W-1:0]   i_row,
    input  wire logic [psmm_pkg::IDX_W-1:0]   i_col,
    input  wire logic [psmm_pkg::DATA_W-1:0]  i_value,
    input  wire psmm_pkg::t_cfg               i_cfg,
    output logic                              o_push,
    input  wire logic                         i_push_ready,
    output psmm_pkg::t_cmd                    o_cmd
);

    logic w_oor;
    logic w_keep;

    assign w_oor = ({1'b0, i_row} >= i_cfg.rows_a) || ({1'b0, i_col} >= i_cfg.cols_b);

    always_comb begin
        o_cmd.row   = i_row;
        o_cmd.col   = i_col;
        o_cmd.value = i_value;
        o_cmd.oor   = w_oor;
        o_cmd.kind  = psmm_pkg::CMD_RD_ZERO;
        w_keep      = 1'b1;
        case (psmm_pkg::t_op'(i_op))
            psmm_pkg::OP_WR_A: o_cmd.kind = psmm_pkg::CMD_WR_A;
            psmm_pkg::OP_WR_B: o_cmd.kind = psmm_pkg::CMD_WR_B;
            psmm_pkg::OP_RD: begin
                if (w_oor || psmm_pkg::inner_len(i_cfg) == '0) begin
                    o_cmd.kind = psmm_pkg::CMD_RD_ZERO;
                end else begin
                    o_cmd.kind = psmm_pkg::CMD_RD;
                end
            end
            default: w_keep = 1'b0;
        endcase
    end

    assign o_ready = i_push_ready;
    assign o_push  = i_valid && w_keep;

endmodule
`default_nettype wire

[rtl/core/psmm_queue.sv]
// Short command queue between the front end and the back end.
// Depends on psmm_pkg.
`default_nettype none
module psmm_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    output logic                 o_push_ready,
    input  wire psmm_pkg::t_cmd  i_cmd,
    output logic                 o_valid,
    input  wire logic            i_pop,
    output psmm_pkg::t_cmd       o_cmd
);

    psmm_pkg::t_cmd                r_mem [psmm_pkg::QDEPTH];
    logic [psmm_pkg::QPTR_W-1:0]   r_wr_ptr;
    logic [psmm_pkg::QPTR_W-1:0]   r_rd_ptr;
    logic [psmm_pkg::QCNT_W-1:0]   r_count;
    logic                          w_wr;
    logic                          w_rd;

    assign o_push_ready = (r_count != psmm_pkg::QCNT_W'(psmm_pkg::QDEPTH));
    assign o_valid      = (r_count != '0);
    assign w_wr         = i_push && o_push_ready;
    assign w_rd         = i_pop && o_valid;
    assign o_cmd        = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({w_wr, w_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= psmm_pkg::QCNT_W'(psmm_pkg::QDEPTH))
        else $error("queue count above depth");

    a_pop_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_rd && !w_wr) |=> (r_count == $past(r_count) - 1'b1))
        else $error("queue count lost a pop");

endmodule
`default_nettype wire

[rtl/core/psmm_back.sv]
// Back end: matrix stores, multiply-accumulate loop and output register.
// Depends on psmm_pkg; consumes commands from psmm_queue.
`default_nettype none
module psmm_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire psmm_pkg::t_cfg               i_cfg,
    input  wire logic                         i_q_valid,
    input  wire psmm_pkg::t_cmd               i_cmd,
    output logic                              o_pop,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [psmm_pkg::DATA_W-1:0]       o_value,
    output logic                              o_oor
);

    logic [psmm_pkg::DATA_W-1:0]   mem_a [psmm_pkg::MAX_DIM * psmm_pkg::MAX_DIM];
    logic [psmm_pkg::DATA_W-1:0]   mem_b [psmm_pkg::MAX_DIM * psmm_pkg::MAX_DIM];

    psmm_pkg::t_back_state         r_state;
    psmm_pkg::t_back_state         n_state;
    logic [psmm_pkg::IDX_W-1:0]    r_k;
    logic [psmm_pkg::IDX_W-1:0]    r_row;
    logic [psmm_pkg::IDX_W-1:0]    r_col;
    logic [psmm_pkg::CFG_W-1:0]    r_last;
    logic [psmm_pkg::DATA_W-1:0]   r_a_rd;
    logic [psmm_pkg::DATA_W-1:0]   r_b_rd;
    logic                          r_rd_vld;
    logic [psmm_pkg::DATA_W-1:0]   r_prod;
    logic                          r_prod_vld;
    logic [psmm_pkg::DATA_W-1:0]   r_acc;
    logic                          r_out_valid;
    logic [psmm_pkg::DATA_W-1:0]   r_out_value;
    logic                          r_out_oor;
    logic [psmm_pkg::DATA_W-1:0]   w_prod;

    logic                          w_we_a;
    logic                          w_we_b;
    logic                          w_issue;
    logic                          w_start;
    logic                          w_load;
    logic [psmm_pkg::DATA_W-1:0]   w_load_value;
    logic                          w_load_oor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= psmm_pkg::BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_pop        = 1'b0;
        w_we_a       = 1'b0;
        w_we_b       = 1'b0;
        w_issue      = 1'b0;
        w_start      = 1'b0;
        w_load       = 1'b0;
        w_load_value = '0;
        w_load_oor   = 1'b0;
        case (r_state)
            psmm_pkg::BK_IDLE: begin
                if (i_q_valid) begin
                    case (i_cmd.kind)
                        psmm_pkg::CMD_WR_A: begin
                            o_pop  = 1'b1;
                            w_we_a = 1'b1;
                        end
                        psmm_pkg::CMD_WR_B: begin
                            o_pop  = 1'b1;
                            w_we_b = 1'b1;
                        end
                        psmm_pkg::CMD_RD: begin
                            if (!r_out_valid) begin
                                o_pop   = 1'b1;
                                w_start = 1'b1;
                                n_state = psmm_pkg::BK_ISSUE;
                            end
                        end
                        default: begin
                            if (!r_out_valid) begin
                                o_pop      = 1'b1;
                                w_load     = 1'b1;
                                w_load_oor = i_cmd.oor;
                            end
                        end
                    endcase
                end
            end
            psmm_pkg::BK_ISSUE: begin
                w_issue = 1'b1;
                if ({1'b0, r_k} == r_last) begin
                    n_state = psmm_pkg::BK_DRAIN;
                end
            end
            psmm_pkg::BK_DRAIN: begin
                if (!r_rd_vld && !r_prod_vld) begin
                    w_load       = 1'b1;
                    w_load_value = r_acc;
                    n_state      = psmm_pkg::BK_IDLE;
                end
            end
            default: n_state = psmm_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we_a) begin
            mem_a[{i_cmd.row, i_cmd.col}] <= i_cmd.value;
        end
        if (w_issue) begin
            r_a_rd <= mem_a[{r_row, r_k}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we_b) begin
            mem_b[{i_cmd.row, i_cmd.col}] <= i_cmd.value;
        end
        if (w_issue) begin
            r_b_rd <= mem_b[{r_k, r_col}];
        end
    end

    assign w_prod = r_a_rd * r_b_rd;

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        if (w_start) begin
            r_row  <= i_cmd.row;
            r_col  <= i_cmd.col;
            r_last <= psmm_pkg::inner_len(i_cfg) - 1'b1;
            r_k    <= '0;
            r_acc  <= '0;
        end else begin
            if (w_issue) begin
                r_k <= r_k + 1'b1;
            end
            if (r_prod_vld) begin
                r_acc <= r_acc + r_prod;
            end
        end
        if (w_load) begin
            r_out_value <= w_load_value;
            r_out_oor   <= w_load_oor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld    <= 1'b0;
            r_prod_vld  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_vld   <= w_issue;
            r_prod_vld <= r_rd_vld;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_value = r_out_value;
    assign o_oor   = r_out_oor;

    a_no_result_in_loop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == psmm_pkg::BK_ISSUE || r_state == psmm_pkg::BK_DRAIN) |-> !r_out_valid)
        else $error("result pending while accumulating");

    a_oor_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_oor) |-> (r_out_value == '0))
        else $error("out-of-range result carries a value");

    a_drain_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == psmm_pkg::BK_DRAIN && !r_rd_vld && !r_prod_vld)
        |=> (r_out_valid && r_state == psmm_pkg::BK_IDLE))
        else $error("finished dot product not delivered");

endmodule
`default_nettype wire

[rtl/core/padded_square_matrix_multiply.sv]
// Top level of the padded square matrix multiply: configuration registers,
// front end, command queue and back end. Depends on psmm_pkg and psmm_* modules.
//
//   channel  | handshake            | payload
//   ---------+----------------------+--------------------------------------
//   input    | i_valid / o_ready    | i_op, i_row, i_col, i_value
//   result   | o_valid / i_ready    | o_product_value, o_out_of_range
//   config   | i_cfg_we             | i_cfg_index, i_cfg_data
//
// Writes are stored while the back end idles; out-of-range or empty reads give zero.
// A read accumulates inner products, inner = min(cols_a, rows_b) capped at 16, paced
// by the single multiply-accumulate and the one read port of each store.
// Reset is synchronous: registers go to 16, queue and control clear; stores stay.
// Up to two beats queue while the back end works or its result waits.
`default_nettype none
module padded_square_matrix_multiply (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [psmm_pkg::OP_W-1:0]      i_op,
    input  wire logic [psmm_pkg::IDX_W-1:0]     i_row,
    input  wire logic [psmm_pkg::IDX_W-1:0]     i_col,
    input  wire logic signed [psmm_pkg::DATA_W-1:0] i_value,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic signed [psmm_pkg::DATA_W-1:0]  o_product_value,
    output logic                                o_out_of_range,
    input  wire logic                           i_cfg_we,
    input  wire logic [psmm_pkg::CIDX_W-1:0]    i_cfg_index,
    input  wire logic [psmm_pkg::CFG_W-1:0]     i_cfg_data
);

    psmm_pkg::t_cfg               r_cfg;
    logic                         w_push;
    logic                         w_push_ready;
    psmm_pkg::t_cmd               w_front_cmd;
    logic                         w_q_valid;
    logic                         w_pop;
    psmm_pkg::t_cmd               w_q_cmd;
    logic [psmm_pkg::DATA_W-1:0]  w_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rows_a <= psmm_pkg::DIM_LIMIT;
            r_cfg.cols_a <= psmm_pkg::DIM_LIMIT;
            r_cfg.rows_b <= psmm_pkg::DIM_LIMIT;
            r_cfg.cols_b <= psmm_pkg::DIM_LIMIT;
        end else if (i_cfg_we) begin
            case (psmm_pkg::t_cfg_idx'(i_cfg_index))
                psmm_pkg::CFG_ROWS_A: r_cfg.rows_a <= i_cfg_data;
                psmm_pkg::CFG_COLS_A: r_cfg.cols_a <= i_cfg_data;
                psmm_pkg::CFG_ROWS_B: r_cfg.rows_b <= i_cfg_data;
                psmm_pkg::CFG_COLS_B: r_cfg.cols_b <= i_cfg_data;
                default:              r_cfg        <= r_cfg;
            endcase
        end
    end

    psmm_front u_front (
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_op         (i_op),
        .i_row        (i_row),
        .i_col        (i_col),
        .i_value      (psmm_pkg::DATA_W'(unsigned'(i_value))),
        .i_cfg        (r_cfg),
        .o_push       (w_push),
        .i_push_ready (w_push_ready),
        .o_cmd        (w_front_cmd)
    );

    psmm_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .o_push_ready (w_push_ready),
        .i_cmd        (w_front_cmd),
        .o_valid      (w_q_valid),
        .i_pop        (w_pop),
        .o_cmd        (w_q_cmd)
    );

    psmm_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (w_q_valid),
        .i_cmd     (w_q_cmd),
        .o_pop     (w_pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_value   (w_value),
        .o_oor     (o_out_of_range)
    );

    assign o_product_value = signed'(w_value);

endmodule
`default_nettype wire
